[rtl/wpm_pkg.sv]
// Package for the wildcard pattern matcher: sizes, symbol codes, operation
// codes and the types shared by the top level, the row step and the checker.
// No dependencies.
package wpm_pkg;

    // Longest pattern the store holds
    localparam int PAT_MAX  = 32;
    // Match row: one bit per pattern prefix, empty prefix included
    localparam int ROW_W    = PAT_MAX + 1;
    localparam int LEN_W    = $clog2(PAT_MAX + 1);
    localparam int IDX_W    = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    // Levels of the parallel prefix network over the row
    localparam int ROW_LVLS = (ROW_W > 1) ? $clog2(ROW_W) : 1;

    // Pattern meta characters
    localparam logic [7:0] SYM_ONE = 8'h2E;  // '.' exactly one byte
    localparam logic [7:0] SYM_OPT = 8'h3F;  // '?' zero or one byte
    localparam logic [7:0] SYM_ANY = 8'h2A;  // '*' any run

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_RESTART = 2'd2,
        OP_TEXT    = 2'd3
    } op_t;

    typedef logic [ROW_W-1:0]        row_t;
    typedef logic [LEN_W-1:0]        len_t;
    typedef logic [PAT_MAX-1:0][7:0] pat_store_t;

    // Everything one item does to the state, and its result
    typedef struct packed {
        row_t row;
        len_t len;
        logic store_we;
        logic matched;
        logic overflow;
    } step_t;

endpackage

[rtl/wpm_row_step.sv]
// Row step of the wildcard pattern matcher: next match row, pattern length,
// store write enable and result for one item. Combinational.
// Depends on wpm_pkg.
module wpm_row_step
    import wpm_pkg::*;
(
    input  op_t        op,
    input  logic [7:0] sym,
    input  pat_store_t store,
    input  row_t       row,
    input  len_t       len,
    output step_t      step
);

    // Carry chain c[j] = g[j] | p[j] & c[j-1], c[-1] = 0, as a log-depth prefix network
    function automatic row_t prefix_scan(input row_t g_in, input row_t p_in);
        row_t gv;
        row_t pv;
        row_t gn;
        row_t pn;
        gv = g_in;
        pv = p_in;
        for (int l = 0; l < ROW_LVLS; l++)
        begin
            gn = gv;
            pn = pv;
            for (int j = 0; j < ROW_W; j++)
            begin
                if (j >= (1 << l))
                begin
                    gn[j] = gv[j] | (pv[j] & gv[j - (1 << l)]);
                    pn[j] = pv[j] & pv[j - (1 << l)];
                end
            end
            gv = gn;
            pv = pn;
        end
        return gv;
    endfunction

    pat_store_t view;
    logic       full;
    logic       do_append;
    len_t       len_new;
    row_t       empty_g;
    row_t       empty_p;
    row_t       text_g;
    row_t       text_p;
    row_t       empty_col;
    row_t       text_row;
    row_t       row_new;

    assign full      = (len == len_t'(PAT_MAX));
    assign do_append = (op == OP_APPEND) && !full;

    // Store as it reads after this item's append
    always_comb
    begin
        for (int i = 0; i < PAT_MAX; i++)
        begin
            view[i] = (do_append && (len == len_t'(i))) ? sym : store[i];
        end
    end

    // Empty text: a prefix matches only if every byte is '?' or '*'
    always_comb
    begin
        empty_g    = '0;
        empty_p    = '0;
        empty_g[0] = 1'b1;
        for (int j = 1; j < ROW_W; j++)
        begin
            empty_p[j] = (view[j-1] == SYM_OPT) || (view[j-1] == SYM_ANY);
        end
    end

    // One text byte: old row diagonal ('*' same column), '?' and '*' ripple along the new row
    always_comb
    begin
        text_g = '0;
        text_p = '0;
        for (int j = 1; j < ROW_W; j++)
        begin
            if (view[j-1] == SYM_ONE)
            begin
                text_g[j] = row[j-1];
            end
            else if (view[j-1] == SYM_OPT)
            begin
                text_g[j] = row[j-1];
                text_p[j] = 1'b1;
            end
            else if (view[j-1] == SYM_ANY)
            begin
                text_g[j] = row[j];
                text_p[j] = 1'b1;
            end
            else
            begin
                text_g[j] = (view[j-1] == sym) & row[j-1];
            end
        end
    end

    assign empty_col = prefix_scan(empty_g, empty_p);
    assign text_row  = prefix_scan(text_g, text_p);

    always_comb
    begin
        len_new = len;
        row_new = row;
        case (op)
            OP_CLEAR:
            begin
                len_new = '0;
                row_new = empty_col;
            end
            OP_APPEND:
            begin
                if (!full)
                begin
                    len_new = len + len_t'(1);
                    row_new = empty_col;
                end
            end
            OP_RESTART:
            begin
                row_new = empty_col;
            end
            OP_TEXT:
            begin
                row_new = text_row;
            end
            default:
            begin
                row_new = row;
            end
        endcase
    end

    assign step.row      = row_new;
    assign step.len      = len_new;
    assign step.store_we = do_append;
    assign step.matched  = row_new[len_new];
    assign step.overflow = (op == OP_APPEND) && full;

endmodule

[rtl/wildcard_pattern_matcher_unit.sv]
// Top level of the wildcard pattern matcher: input register, pattern store,
// match row state and result register. Depends on wpm_pkg and wpm_row_step.
//
//   channel  handshake            payload                      direction
//   input    in_valid / in_ready  operation[1:0], symbol[7:0]  into block
//   output   out_valid/out_ready  matched, pattern_overflow    out of block
//
// One item per cycle sustained while the output is not stalled; a result
// passes through the input register, which takes the item, and then the
// result register, which loads once it is free. That rate is set by
// the combinational row step: a byte compare per pattern position and a
// ripple of '?' and '*' done as a prefix network of log2(PAT_MAX+1) levels.
// Reset clears the pattern length and leaves only the empty-prefix bit set in
// the match row; the pattern store itself is not cleared.
// A stalled result holds in the result register; the input register still
// takes a new item, then the input side stalls until the result moves.
module wildcard_pattern_matcher_unit
    import wpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] symbol,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       pattern_overflow
);

    // Input register
    logic       in_valid_reg;
    op_t        in_op_reg;
    logic [7:0] in_sym_reg;

    // Block state
    pat_store_t store_reg;
    len_t       len_reg;
    row_t       row_reg;

    // Result register
    logic       out_valid_reg;
    logic       matched_reg;
    logic       overflow_reg;
    logic       out_valid_next;

    step_t      step;
    logic       advance;

    // Move the held item into the result register when that register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    wpm_row_step u_row_step (
        .op    (in_op_reg),
        .sym   (in_sym_reg),
        .store (store_reg),
        .row   (row_reg),
        .len   (len_reg),
        .step  (step)
    );

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input payload: load on every transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_op_reg  <= op_t'(operation);
            in_sym_reg <= symbol;
        end
    end

    // Pattern store: written at the current length on an accepted append
    always_ff @(posedge clk)
    begin
        if (advance && step.store_we)
        begin
            store_reg[len_reg[IDX_W-1:0]] <= in_sym_reg;
        end
    end

    // Length and match row advance once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            row_reg <= row_t'(1);
        end
        else if (advance)
        begin
            len_reg <= step.len;
            row_reg <= step.row;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            matched_reg  <= step.matched;
            overflow_reg <= step.overflow;
        end
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = overflow_reg;

endmodule

[rtl/wpm_checker.sv]
// Port-level checker for the wildcard pattern matcher, with its bind to the
// top level. Tracks the operation codes in flight. Depends on wpm_pkg.
module wpm_checker
    import wpm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] operation,
    input logic       out_valid,
    input logic       out_ready,
    input logic       matched,
    input logic       pattern_overflow
);

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    op_t        q0_reg;
    op_t        q1_reg;
    logic       slot;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign occ_next = occ_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
    assign slot     = (occ_reg - {1'b0, out_xfer}) != 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // In-order queue of operations: drop the head on a result transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer && !slot)
        begin
            q0_reg <= op_t'(operation);
        end
        else if (out_xfer)
        begin
            q0_reg <= q1_reg;
        end
        if (in_xfer && slot)
        begin
            q1_reg <= op_t'(operation);
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(matched) && $stable(pattern_overflow))
        else $error("result changed while stalled");

    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg <= 2'd2) && (!out_valid || occ_reg != 2'd0))
        else $error("result without a pending item, or too many items in flight");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && occ_reg != 2'd0 && q0_reg == OP_CLEAR |-> matched && !pattern_overflow)
        else $error("clear must report an empty match without overflow");

    a_overflow_append: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && occ_reg != 2'd0 && q0_reg != OP_APPEND |-> !pattern_overflow)
        else $error("overflow flagged on an item that is not an append");

endmodule

bind wildcard_pattern_matcher_unit wpm_checker u_wpm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
);
